/* hw/rtl/dlt_pkg.sv */
package dlt_pkg;

	localparam logic [7:0] StartByte  = 8'h68;
	localparam logic [7:0] EndByte    = 8'h16;
	localparam logic [7:0] DataOffset = 8'h33;
	localparam int         HdrBytes   = 8;
	localparam logic [2:0] HdrLast    = 3'(HdrBytes - 1);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HDR,
		PH_CTRL,
		PH_LEN,
		PH_DATA,
		PH_CSUM,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_CSUM_ERR = 2'd1,
		ST_END_ERR  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        frame_end;
		logic [47:0] meter_address;
		logic [7:0]  control_code;
		logic [7:0]  data_length;
		status_t     status;
	} res_t;

endpackage

/* hw/rtl/dlt_rx_if.sv */
interface dlt_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/dlt_res_if.sv */
interface dlt_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        frame_end;
	logic [47:0] meter_address;
	logic [7:0]  control_code;
	logic [7:0]  data_length;
	logic [1:0]  status;

	modport source (output valid, output data_byte, output frame_end, output meter_address,
		output control_code, output data_length, output status, input ready);
	modport sink (input valid, input data_byte, input frame_end, input meter_address,
		input control_code, input data_length, input status, output ready);
endinterface

/* hw/rtl/dlt645_frame_deframer.sv */
// Channel  Dir  Payload                                              Request
// rx       in   rx_byte                                              one received byte
// res      out  data_byte, frame_end, meter_address, control_code,   data byte or
//               data_length, status                                  frame end item
//
// One byte per cycle; frame state and result are updated in the cycle a byte is taken.
// Results pass through a two-entry output buffer; rx.ready drops only while it is full.
// Each result is registered in the output buffer and is presented on res from there.
// arst_n clears the frame state and empties the buffer; the block then hunts for 0x68.
module dlt645_frame_deframer (
	input logic        clk,
	input logic        arst_n,
	dlt_rx_if.sink     rx,
	dlt_res_if.source  res
);

	dlt_pkg::phase_t phase_q, phase_d;
	logic [7:0] win_q [dlt_pkg::HdrBytes];
	logic [7:0] win_d [dlt_pkg::HdrBytes];
	logic [7:0] win_src [dlt_pkg::HdrBytes];
	logic [7:0] win_shift [dlt_pkg::HdrBytes];
	logic [2:0] hdr_cnt_q, hdr_cnt_d;
	logic [7:0] data_cnt_q, data_cnt_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] ctrl_q, ctrl_d;
	logic [7:0] len_q, len_d;
	logic [7:0] csum_q, csum_d;
	logic [7:0] hdr_sum;
	logic       shift_hit;
	logic [2:0] shift_j;
	logic [7:0] b;
	logic       acc;
	logic       emit;
	dlt_pkg::res_t res_d;

	dlt_pkg::res_t buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign b   = rx.rx_byte;
	assign acc = rx.valid && rx.ready;

	// first later start byte among held offsets 1..6
	always_comb begin
		shift_hit = 1'b0;
		shift_j   = '0;
		for (int k = 6; k >= 1; k--) begin
			if (win_q[k] == dlt_pkg::StartByte) begin
				shift_hit = 1'b1;
				shift_j   = 3'(k);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < dlt_pkg::HdrBytes; k++) begin
			win_src[k] = win_q[k];
		end
		win_src[dlt_pkg::HdrBytes - 1] = b;
		for (int k = 0; k < dlt_pkg::HdrBytes; k++) begin
			win_shift[k] = win_src[k];
			for (int jj = 1; jj < dlt_pkg::HdrBytes - 1; jj++) begin
				if (shift_j == 3'(jj) && k + jj < dlt_pkg::HdrBytes) begin
					win_shift[k] = win_src[k + jj];
				end
			end
		end
	end

	always_comb begin
		hdr_sum = b;
		for (int k = 0; k < dlt_pkg::HdrBytes - 1; k++) begin
			hdr_sum = hdr_sum + win_q[k];
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			unique case (phase_q)
				dlt_pkg::PH_HUNT: begin
					if (b == dlt_pkg::StartByte) phase_d = dlt_pkg::PH_HDR;
				end
				dlt_pkg::PH_HDR: begin
					if (hdr_cnt_q == dlt_pkg::HdrLast) begin
						if (b == dlt_pkg::StartByte) phase_d = dlt_pkg::PH_CTRL;
						else if (!shift_hit) phase_d = dlt_pkg::PH_HUNT;
					end
				end
				dlt_pkg::PH_CTRL: phase_d = dlt_pkg::PH_LEN;
				dlt_pkg::PH_LEN: begin
					phase_d = (b == 8'd0) ? dlt_pkg::PH_CSUM : dlt_pkg::PH_DATA;
				end
				dlt_pkg::PH_DATA: begin
					if (data_cnt_q == 8'd1) phase_d = dlt_pkg::PH_CSUM;
				end
				dlt_pkg::PH_CSUM: phase_d = dlt_pkg::PH_END;
				dlt_pkg::PH_END:  phase_d = dlt_pkg::PH_HUNT;
				default:          phase_d = dlt_pkg::PH_HUNT;
			endcase
		end
	end

	// datapath and results
	always_comb begin
		win_d      = win_q;
		hdr_cnt_d  = hdr_cnt_q;
		data_cnt_d = data_cnt_q;
		sum_d      = sum_q;
		ctrl_d     = ctrl_q;
		len_d      = len_q;
		csum_d     = csum_q;
		emit       = 1'b0;
		res_d      = '0;
		if (acc) begin
			unique case (phase_q)
				dlt_pkg::PH_HUNT: begin
					if (b == dlt_pkg::StartByte) begin
						win_d[0]  = b;
						hdr_cnt_d = 3'd1;
					end
				end
				dlt_pkg::PH_HDR: begin
					if (hdr_cnt_q != dlt_pkg::HdrLast) begin
						win_d[hdr_cnt_q] = b;
						hdr_cnt_d        = hdr_cnt_q + 3'd1;
					end else if (b == dlt_pkg::StartByte) begin
						win_d[dlt_pkg::HdrBytes - 1] = b;
						sum_d = hdr_sum;
					end else if (shift_hit) begin
						win_d     = win_shift;
						hdr_cnt_d = 3'(dlt_pkg::HdrBytes) - shift_j;
					end else begin
						win_d[dlt_pkg::HdrBytes - 1] = b;
					end
				end
				dlt_pkg::PH_CTRL: begin
					ctrl_d = b;
					sum_d  = sum_q + b;
				end
				dlt_pkg::PH_LEN: begin
					len_d      = b;
					data_cnt_d = b;
					sum_d      = sum_q + b;
				end
				dlt_pkg::PH_DATA: begin
					sum_d           = sum_q + b;
					data_cnt_d      = data_cnt_q - 8'd1;
					emit            = 1'b1;
					res_d.data_byte = b - dlt_pkg::DataOffset;
				end
				dlt_pkg::PH_CSUM: begin
					csum_d = b;
				end
				dlt_pkg::PH_END: begin
					emit                = 1'b1;
					sum_d               = '0;
					res_d.frame_end     = 1'b1;
					res_d.meter_address = {win_q[6], win_q[5], win_q[4],
						win_q[3], win_q[2], win_q[1]};
					res_d.control_code  = ctrl_q;
					res_d.data_length   = len_q;
					if (csum_q != sum_q) res_d.status = dlt_pkg::ST_CSUM_ERR;
					else if (b != dlt_pkg::EndByte) res_d.status = dlt_pkg::ST_END_ERR;
					else res_d.status = dlt_pkg::ST_GOOD;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dlt_pkg::PH_HUNT;
			hdr_cnt_q  <= '0;
			data_cnt_q <= '0;
			sum_q      <= '0;
			ctrl_q     <= '0;
			len_q      <= '0;
			csum_q     <= '0;
			for (int k = 0; k < dlt_pkg::HdrBytes; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			data_cnt_q <= data_cnt_d;
			sum_q      <= sum_d;
			ctrl_q     <= ctrl_d;
			len_q      <= len_d;
			csum_q     <= csum_d;
			win_q      <= win_d;
		end
	end

	// two-entry output buffer
	assign push     = emit;
	assign pop      = res.valid && res.ready;
	assign rx.ready = (cnt_q != 2'd2);
	assign res.valid = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= res_d;
	end

	assign res.data_byte     = buf_q[rd_ptr_q].data_byte;
	assign res.frame_end     = buf_q[rd_ptr_q].frame_end;
	assign res.meter_address = buf_q[rd_ptr_q].meter_address;
	assign res.control_code  = buf_q[rd_ptr_q].control_code;
	assign res.data_length   = buf_q[rd_ptr_q].data_length;
	assign res.status        = buf_q[rd_ptr_q].status;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_end_phase: assert property (@(posedge clk) disable iff (!arst_n)
		push && res_d.frame_end |-> phase_q == dlt_pkg::PH_END)
		else $error("frame end outside end phase");

	a_hdr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == dlt_pkg::PH_CTRL |->
			win_q[0] == dlt_pkg::StartByte && win_q[7] == dlt_pkg::StartByte)
		else $error("header accepted without both start bytes");

	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == dlt_pkg::PH_DATA |-> data_cnt_q != 8'd0)
		else $error("data phase with no bytes left");

endmodule
